>>> design/sfa_pkg.sv
// Shared constants, command codes and status codes of the section frame allocator.
package sfa_pkg;

    localparam int FRAME_COUNT   = 512;
    localparam int SECTION_SHIFT = 20;

    localparam int ADDR_W    = 32;
    localparam int SECTION_W = 12;
    localparam int FIRST_W   = 10;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;

    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((ADDR_W + FIRST_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = ((CMD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = ((STATUS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_PHYS_BASE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOT_TABLE = 1'd1;

    localparam logic [SECTION_W-1:0] PHYS_BASE_RESET  = 12'd2048;
    localparam logic [SECTION_W-1:0] BOOT_TABLE_RESET = 12'd2048;

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;

endpackage

>>> design/section_frame_allocator_unit.sv
// Section frame allocator: LIFO free list of physical sections with a double-free bitmap.

// The block hands out physical memory sections from a last-in first-out free
// list held in a FRAME_COUNT-entry stack memory, with a one-bit-per-frame
// bitmap memory that marks the frames on the list. Commands arrive on the
// slave stream: init rebuilds the list, alloc pops the top frame and returns
// its byte address, free checks alignment, range and double free and pushes
// the frame. Every command gives exactly one result transfer on the master
// stream. One command is worked on at a time and s_tready is high only while
// the sequencer is idle; a result may still wait on the output register while
// the next command is taken. Alloc makes one registered stack read, then the
// bitmap update; free makes one registered bitmap read when its checks pass;
// init sweeps every frame once through the bitmap, one frame a cycle, pushing
// the eligible ones. After reset the block first clears the bitmap in a pass
// over all FRAME_COUNT frames (512 by default), during which no command is
// accepted; configuration writes are taken at any time.
module section_frame_allocator_unit
    import sfa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_TDATA_W-1:0]       s_tdata,   // [31:0] frame_addr, [41:32] first_frame
    input  logic [IN_TUSER_W-1:0]       s_tuser,   // [1:0] command

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [31:0] alloc_addr
    output logic [OUT_TUSER_W-1:0]      m_tuser,   // [2:0] status

    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [SECTION_W-1:0]        cfg_data
);

    localparam int SUM_W  = ((SECTION_W > IDX_W) ? SECTION_W : IDX_W) + 1;
    localparam int FULL_W = ((SUM_W + SECTION_SHIFT) > ADDR_W) ?
                            (SUM_W + SECTION_SHIFT) : ADDR_W;
    localparam int SEC_W  = ADDR_W - SECTION_SHIFT;
    localparam int CMP_W  = ((SEC_W > SECTION_W) ? SEC_W : SECTION_W) + 1;
    localparam int FIRST_CMP_W = (IDX_W > FIRST_W) ? IDX_W : FIRST_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC_WR,
        S_FREE_CHK,
        S_FREE_DEC,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       walk_reg, walk_next;
    logic [CNT_W-1:0]       stack_count_reg, stack_count_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [FIRST_W-1:0]     first_reg, first_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [SECTION_W-1:0]   base_reg;
    logic [SECTION_W-1:0]   boot_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0]      m_addr_reg, m_addr_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    // Free stack and free bitmap memories.
    logic [IDX_W-1:0]       stack_mem [FRAME_COUNT];
    logic                   map_mem [FRAME_COUNT];
    logic [IDX_W-1:0]       stack_rdata_reg;
    logic                   map_rdata_reg;
    logic                   stack_we, map_we, map_wdata;
    logic [IDX_W-1:0]       stack_waddr, stack_wdata, stack_raddr;
    logic [IDX_W-1:0]       map_waddr, map_raddr;

    // Shared section adder: base plus a frame index.
    logic [IDX_W-1:0]       add_op;
    logic [SUM_W-1:0]       sec_sum;
    logic [FULL_W-1:0]      frame_full;

    // Free-path checks.
    logic [SEC_W-1:0]       free_sec;
    logic [CMP_W-1:0]       free_diff;
    logic [IDX_W-1:0]       free_idx;
    logic                   free_unaligned;
    logic                   free_in_range;

    logic                   init_push;
    logic                   accept;
    logic [CNT_W-1:0]       count_dec;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TDATA_W'(m_addr_reg);
    assign m_tuser   = OUT_TUSER_W'(m_status_reg);

    assign add_op     = (state_reg == S_ALLOC_WR) ? stack_rdata_reg : walk_reg;
    assign sec_sum    = SUM_W'(base_reg) + SUM_W'(add_op);
    assign frame_full = FULL_W'(sec_sum) << SECTION_SHIFT;

    assign free_sec       = addr_reg[ADDR_W-1:SECTION_SHIFT];
    assign free_unaligned = (addr_reg[SECTION_SHIFT-1:0] != '0);
    assign free_diff      = CMP_W'(free_sec) - CMP_W'(base_reg);
    // A negative difference wraps to at least half the range, beyond any frame count.
    assign free_in_range  = (free_diff < CMP_W'(FRAME_COUNT));
    assign free_idx       = free_diff[IDX_W-1:0];

    assign init_push = (FIRST_CMP_W'(walk_reg) >= FIRST_CMP_W'(first_reg)) &&
                       (sec_sum != SUM_W'(boot_reg));

    assign count_dec   = stack_count_reg - CNT_W'(1);
    assign stack_raddr = count_dec[IDX_W-1:0];
    assign map_raddr   = free_idx;

    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        stack_count_next = stack_count_reg;
        addr_next        = addr_reg;
        first_next       = first_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_addr_next      = m_addr_reg;
        m_status_next    = m_status_reg;
        stack_we         = 1'b0;
        stack_waddr      = stack_count_reg[IDX_W-1:0];
        stack_wdata      = walk_reg;
        map_we           = 1'b0;
        map_waddr        = walk_reg;
        map_wdata        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
                walk_next = walk_reg + IDX_W'(1);
                if (walk_reg == IDX_W'(FRAME_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next       = s_tdata[ADDR_W-1:0];
                    first_next      = s_tdata[ADDR_W+FIRST_W-1:ADDR_W];
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    case (s_tuser[CMD_W-1:0])
                        CMD_INIT:
                        begin
                            stack_count_next = '0;
                            walk_next        = '0;
                            state_next       = S_INIT;
                        end
                        CMD_ALLOC:
                        begin
                            if (stack_count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                // The stack read of the top entry is issued this cycle.
                                stack_count_next = count_dec;
                                state_next       = S_ALLOC_WR;
                            end
                        end
                        CMD_FREE:
                        begin
                            state_next = S_FREE_CHK;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                map_we    = 1'b1;
                map_wdata = init_push;
                if (init_push)
                begin
                    stack_we         = 1'b1;
                    stack_count_next = stack_count_reg + CNT_W'(1);
                end
                walk_next = walk_reg + IDX_W'(1);
                if (walk_reg == IDX_W'(FRAME_COUNT - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_ALLOC_WR:
            begin
                map_we        = 1'b1;
                map_waddr     = stack_rdata_reg;
                map_wdata     = 1'b0;
                res_addr_next = frame_full[ADDR_W-1:0];
                state_next    = S_EMIT;
            end
            S_FREE_CHK:
            begin
                if (free_unaligned)
                begin
                    res_status_next = ST_UNALIGNED;
                    state_next      = S_EMIT;
                end
                else if (!free_in_range)
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    // Bitmap read of the frame is issued this cycle.
                    state_next = S_FREE_DEC;
                end
            end
            S_FREE_DEC:
            begin
                if (map_rdata_reg)
                begin
                    res_status_next = ST_DOUBLE;
                end
                else if (stack_count_reg != CNT_W'(FRAME_COUNT))
                begin
                    stack_we         = 1'b1;
                    stack_wdata      = free_idx;
                    stack_count_next = stack_count_reg + CNT_W'(1);
                    map_we           = 1'b1;
                    map_waddr        = free_idx;
                    map_wdata        = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            walk_reg        <= '0;
            stack_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
            base_reg        <= PHYS_BASE_RESET;
            boot_reg        <= BOOT_TABLE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            walk_reg        <= walk_next;
            stack_count_reg <= stack_count_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHYS_BASE:  base_reg <= cfg_data;
                    REG_BOOT_TABLE: boot_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        first_reg      <= first_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    // The list can never hold more frames than exist.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= CNT_W'(FRAME_COUNT))
        else $error("stack count above frame count");

    // A pop lowers the count by exactly one before the bitmap update.
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_WR) |-> (stack_count_reg == $past(stack_count_reg) - CNT_W'(1)))
        else $error("alloc did not pop one entry");

    // A nonzero address is only returned with an ok status.
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_addr_reg != '0)) |-> (m_status_reg == ST_OK))
        else $error("address returned with a failing status");

    // Only one command is in work at a time.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted while busy");

    // A fresh result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("pending result dropped");

endmodule
